// File: design/bdte_pkg.sv
// Shared types, constants and calendar helpers for the date-to-epoch block.
// No dependencies; used by every module of the block.
package bdte_pkg;

  localparam int YearW = 10;
  localparam int DayW = 42;
  localparam int TodW = 17;
  localparam int MagW = 32;
  localparam int QuotW = 24;
  localparam int RemW = 9;
  localparam int QDepth = 2;
  localparam int QPtrW = 1;
  localparam int QCntW = 2;
  localparam int HiW = DayW - 24;
  localparam int HiProdW = 36;
  localparam int LoProdW = 41;

  localparam int CycleYears = 400;
  localparam int CycleDays = (365 * 400) + 100 - 4 + 1;
  localparam int FoldHigh = 100;
  localparam int FoldLow = -300;
  localparam int BaseOffset = 70;
  localparam int SecsPerDay = 86400;
  localparam int SecsPerHour = 3600;
  localparam int SecsPerMin = 60;
  localparam int LastMonth = 11;

  localparam int DivLowW = 4;
  localparam int OddW = RemW - DivLowW;
  localparam int CycleOdd = CycleYears / (1 << DivLowW);
  localparam int RecipW = 29;
  localparam int RecipProdW = MagW - DivLowW + RecipW;
  localparam int RecipShift = 33;
  localparam int RecipMul = 343597384;

  typedef struct packed {
    logic signed [YearW-1:0] yoff;
    logic                    fold;
    logic                    aneg;
    logic [MagW-1:0]         amag;
    logic [3:0]              month;
    logic [4:0]              mday;
    logic [TodW-1:0]         tod;
  } entry_t;

  function automatic logic is_leap(logic signed [YearW-1:0] off);
    logic [11:0] y;
    logic        cent;
    y = 12'(int'(off) + 1900);
    cent = (y == 12'd1600) || (y == 12'd1700) || (y == 12'd1800) || (y == 12'd1900) ||
           (y == 12'd2000) || (y == 12'd2100) || (y == 12'd2200) || (y == 12'd2300);
    return (y[1:0] == 2'b00) && (!cent || (y == 12'd1600) || (y == 12'd2000));
  endfunction

  function automatic logic [8:0] days_before(logic leap, logic [3:0] mon);
    logic [8:0] d;
    case (mon)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      default: d = 9'd334;
    endcase
    if (leap && (mon >= 4'd2)) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

endpackage

// File: design/bdte_front.sv
// Front end: classifies one incoming date into a queue entry.
// Depends on bdte_pkg.
module bdte_front (
  input  logic signed [31:0]          year_since_1900,
  input  logic [3:0]                  month,
  input  logic [4:0]                  day_of_month,
  input  logic [4:0]                  hour,
  input  logic [5:0]                  minute,
  input  logic [5:0]                  second,
  output bdte_pkg::entry_t            entry
);

  logic signed [32:0] a;
  logic signed [32:0] a_neg;

  always_comb begin
    a = {year_since_1900[31], year_since_1900} - 33'(bdte_pkg::FoldHigh);
    a_neg = -a;
    entry.yoff = year_since_1900[bdte_pkg::YearW-1:0];
    entry.fold = (year_since_1900 > 32'(bdte_pkg::FoldHigh)) ||
                 (year_since_1900 < 32'(bdte_pkg::FoldLow));
    entry.aneg = a[32];
    entry.amag = a[32] ? a_neg[bdte_pkg::MagW-1:0] : a[bdte_pkg::MagW-1:0];
    entry.month = (month > 4'(bdte_pkg::LastMonth)) ? 4'(bdte_pkg::LastMonth) : month;
    entry.mday = day_of_month;
    entry.tod = bdte_pkg::TodW'(hour) * bdte_pkg::TodW'(bdte_pkg::SecsPerHour) +
                bdte_pkg::TodW'(minute) * bdte_pkg::TodW'(bdte_pkg::SecsPerMin) +
                bdte_pkg::TodW'(second);
  end

endmodule

// File: design/bdte_fifo.sv
// Short queue between the front end and the back-end sequencer.
// Depends on bdte_pkg for the entry type and depth.
module bdte_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bdte_pkg::entry_t    wdata,
  output logic                full,
  input  logic                pop,
  output logic                nempty,
  output bdte_pkg::entry_t    rdata
);

  bdte_pkg::entry_t               mem [bdte_pkg::QDepth];
  logic [bdte_pkg::QPtrW-1:0]     wptr;
  logic [bdte_pkg::QPtrW-1:0]     rptr;
  logic [bdte_pkg::QCntW-1:0]     count;
  logic                           do_push;
  logic                           do_pop;

  assign full = (count == bdte_pkg::QCntW'(bdte_pkg::QDepth));
  assign nempty = (count != '0);
  assign rdata = mem[rptr];
  assign do_push = push && !full;
  assign do_pop = pop && nempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: design/bdte_back.sv
// Back end: folds the year by 400-year cycles, walks year lengths, scales
// days into seconds and adds the time of day. Depends on bdte_pkg.
module bdte_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_nempty,
  input  bdte_pkg::entry_t     q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [63:0]   epoch_seconds
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StDiv   = 4'd1;
  localparam logic [3:0] StFix   = 4'd2;
  localparam logic [3:0] StCyc   = 4'd3;
  localparam logic [3:0] StWinit = 4'd4;
  localparam logic [3:0] StWalk  = 4'd5;
  localparam logic [3:0] StMon   = 4'd6;
  localparam logic [3:0] StMul   = 4'd7;
  localparam logic [3:0] StSum   = 4'd8;
  localparam logic [3:0] StOut   = 4'd9;

  logic [3:0]                              state;
  bdte_pkg::entry_t                        item;
  logic [bdte_pkg::RecipProdW-1:0]         recip;
  logic signed [bdte_pkg::YearW-1:0]       yoff;
  logic signed [bdte_pkg::YearW-1:0]       walk;
  logic                                    up;
  logic signed [bdte_pkg::QuotW-1:0]       ncyc;
  logic signed [bdte_pkg::DayW-1:0]        nday;
  logic [bdte_pkg::LoProdW-1:0]            p_lo;
  logic signed [bdte_pkg::HiProdW-1:0]     p_hi;
  logic [63:0]                             prod;

  logic [bdte_pkg::OddW-1:0]               odd_rem;
  logic [bdte_pkg::RemW-1:0]               rem;
  logic [bdte_pkg::QuotW-1:0]              quot;
  logic signed [bdte_pkg::DayW-1:0]        ylen;
  logic signed [bdte_pkg::DayW-1:0]        ncyc_ext;
  logic signed [bdte_pkg::HiProdW-1:0]     hi_ext;
  logic                                    out_free;

  assign q_pop = (state == StIdle) && q_nempty;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    quot = recip[bdte_pkg::RecipShift +: bdte_pkg::QuotW];
    odd_rem = bdte_pkg::OddW'(item.amag[bdte_pkg::RemW-1:bdte_pkg::DivLowW] -
                              bdte_pkg::OddW'(quot[bdte_pkg::OddW-1:0] *
                                              bdte_pkg::OddW'(bdte_pkg::CycleOdd)));
    rem = {odd_rem, item.amag[bdte_pkg::DivLowW-1:0]};
    ylen = bdte_pkg::is_leap(walk) ? bdte_pkg::DayW'(366) : bdte_pkg::DayW'(365);
    ncyc_ext = {{(bdte_pkg::DayW-bdte_pkg::QuotW){ncyc[bdte_pkg::QuotW-1]}}, ncyc};
    hi_ext = {{(bdte_pkg::HiProdW-bdte_pkg::HiW){nday[bdte_pkg::DayW-1]}},
              nday[bdte_pkg::DayW-1:24]};
  end

  always_ff @(posedge clk) begin
    case (state)
      StIdle: begin
        if (q_nempty) begin
          item <= q_data;
          yoff <= q_data.yoff;
          nday <= '0;
        end
      end
      StDiv: begin
        recip <= bdte_pkg::RecipProdW'(item.amag[bdte_pkg::MagW-1:bdte_pkg::DivLowW]) *
                 bdte_pkg::RecipProdW'(bdte_pkg::RecipMul);
      end
      StFix: begin
        ncyc <= item.aneg ? -$signed(quot) : $signed(quot);
        yoff <= item.aneg
              ? bdte_pkg::YearW'(bdte_pkg::FoldHigh) - bdte_pkg::YearW'(rem)
              : bdte_pkg::YearW'(bdte_pkg::FoldHigh) + bdte_pkg::YearW'(rem);
      end
      StCyc: begin
        nday <= ncyc_ext * $signed(bdte_pkg::DayW'(bdte_pkg::CycleDays));
      end
      StWinit: begin
        up <= (yoff > bdte_pkg::YearW'(bdte_pkg::BaseOffset));
        walk <= (yoff > bdte_pkg::YearW'(bdte_pkg::BaseOffset))
              ? bdte_pkg::YearW'(bdte_pkg::BaseOffset)
              : bdte_pkg::YearW'(bdte_pkg::BaseOffset - 1);
      end
      StWalk: begin
        if (up && (walk < yoff)) begin
          nday <= nday + ylen;
          walk <= walk + 1'b1;
        end else if (!up && (walk >= yoff)) begin
          nday <= nday - ylen;
          walk <= walk - 1'b1;
        end
      end
      StMon: begin
        nday <= nday + bdte_pkg::DayW'(bdte_pkg::days_before(bdte_pkg::is_leap(yoff),
                                                             item.month))
                     + bdte_pkg::DayW'(item.mday) - bdte_pkg::DayW'(1);
      end
      StMul: begin
        p_lo <= bdte_pkg::LoProdW'(nday[23:0]) * bdte_pkg::LoProdW'(bdte_pkg::SecsPerDay);
        p_hi <= hi_ext * $signed(bdte_pkg::HiProdW'(bdte_pkg::SecsPerDay));
      end
      StSum: begin
        prod <= {{(64-bdte_pkg::HiProdW-24){p_hi[bdte_pkg::HiProdW-1]}}, p_hi, 24'b0}
              + {{(64-bdte_pkg::LoProdW){1'b0}}, p_lo};
      end
      StOut: begin
        if (out_free) begin
          epoch_seconds <= prod + {{(64-bdte_pkg::TodW){1'b0}}, item.tod};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      out_valid <= 1'b0;
    end else begin
      if ((state == StOut) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        StIdle: begin
          if (q_nempty) begin
            state <= q_data.fold ? StDiv : StWinit;
          end
        end
        StDiv: begin
          state <= StFix;
        end
        StFix: begin
          state <= StCyc;
        end
        StCyc: begin
          state <= StWinit;
        end
        StWinit: begin
          state <= StWalk;
        end
        StWalk: begin
          if (!(up && (walk < yoff)) && !(!up && (walk >= yoff))) begin
            state <= StMon;
          end
        end
        StMon: begin
          state <= StMul;
        end
        StMul: begin
          state <= StSum;
        end
        StSum: begin
          state <= StOut;
        end
        StOut: begin
          if (out_free) begin
            state <= StIdle;
          end
        end
        default: begin
          state <= StIdle;
        end
      endcase
    end
  end

endmodule

// File: design/broken_down_date_to_epoch_seconds_top.sv
// Top level of the UTC date to epoch seconds converter.
// Depends on bdte_pkg, bdte_front, bdte_fifo and bdte_back.
//
// One result per accepted date. The sequencer works on one date at a time:
// it folds the year by 400-year cycles through a reciprocal multiply when
// the year offset lies outside -300..100, then walks one year per cycle over
// |folded year - 70| years (at most 429). A two-entry queue takes new dates
// while the sequencer is busy, and the output register holds a result until
// taken.
module broken_down_date_to_epoch_seconds_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  year_since_1900,
  input  logic [3:0]          month,
  input  logic [4:0]          day_of_month,
  input  logic [4:0]          hour,
  input  logic [5:0]          minute,
  input  logic [5:0]          second,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [63:0]  epoch_seconds
);

  bdte_pkg::entry_t  in_entry;
  bdte_pkg::entry_t  q_data;
  logic              q_full;
  logic              q_nempty;
  logic              q_pop;

  assign in_ready = !q_full;

  bdte_front u_front (
    .year_since_1900 (year_since_1900),
    .month           (month),
    .day_of_month    (day_of_month),
    .hour            (hour),
    .minute          (minute),
    .second          (second),
    .entry           (in_entry)
  );

  bdte_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (in_valid),
    .wdata  (in_entry),
    .full   (q_full),
    .pop    (q_pop),
    .nempty (q_nempty),
    .rdata  (q_data)
  );

  bdte_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_nempty      (q_nempty),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .epoch_seconds (epoch_seconds)
  );

endmodule

// File: sim/broken_down_date_to_epoch_seconds_top_tb.sv
// Testbench for broken_down_date_to_epoch_seconds_top: drives UTC dates, predicts
// the epoch seconds of each one and checks every result in order.
// Depends on the RTL top level only.
module broken_down_date_to_epoch_seconds_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomDates = 1335;
  localparam int CycleLimit = 4_000_000;
  localparam int SettleCycles = 600;
  localparam int PressureCycles = 3000;
  localparam int DaysPer400Years = 146097;
  localparam int YearsPerCycle = 400;
  localparam int FoldAbove = 100;
  localparam int FoldBelow = -300;
  localparam int EpochYearOffset = 70;
  localparam int December = 11;

  class epoch_seconds_predictor;
    longint expected_seconds[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    static function bit is_leap_year(longint off);
      longint y;
      y = off + 1900;
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    static function int month_start(int mi, bit leap);
      int d;
      case (mi)
        0:       d = 0;
        1:       d = 31;
        2:       d = 59;
        3:       d = 90;
        4:       d = 120;
        5:       d = 151;
        6:       d = 181;
        7:       d = 212;
        8:       d = 243;
        9:       d = 273;
        10:      d = 304;
        default: d = 334;
      endcase
      if (leap && mi >= 2) begin
        d = d + 1;
      end
      return d;
    endfunction

    static function longint seconds_since_epoch(int year, logic [3:0] mon, logic [4:0] mday,
                                                logic [4:0] hh, logic [5:0] mm, logic [5:0] ss);
      longint yoff;
      longint days;
      longint ncyc;
      longint walk;
      int mi;
      yoff = year;
      days = 0;
      if (yoff > FoldAbove || yoff < FoldBelow) begin
        ncyc = (yoff - FoldAbove) / YearsPerCycle;
        yoff = yoff - ncyc * YearsPerCycle;
        days = days + ncyc * DaysPer400Years;
      end
      if (yoff > EpochYearOffset) begin
        for (walk = EpochYearOffset; walk < yoff; walk++) begin
          days = days + (is_leap_year(walk) ? 366 : 365);
        end
      end else if (yoff < EpochYearOffset) begin
        for (walk = EpochYearOffset - 1; walk >= yoff; walk--) begin
          days = days - (is_leap_year(walk) ? 366 : 365);
        end
      end
      mi = (mon > December) ? December : int'(mon);
      days = days + month_start(mi, is_leap_year(yoff));
      days = days + longint'(mday) - 1;
      return days * 86400 + longint'(hh) * 3600 + longint'(mm) * 60 + longint'(ss);
    endfunction

    function void note_date(int year, logic [3:0] mon, logic [4:0] mday,
                            logic [4:0] hh, logic [5:0] mm, logic [5:0] ss);
      expected_seconds.push_back(seconds_since_epoch(year, mon, mday, hh, mm, ss));
    endfunction

    function void check_seconds(longint got);
      longint want;
      if (expected_seconds.size() == 0) begin
        $display("%0t: epoch_seconds %0d arrived with no transaction pending", $time, got);
        errors++;
      end else begin
        want = expected_seconds.pop_front();
        if (want != got) begin
          $display("%0t: epoch_seconds expected %0d, actual %0d", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_seconds.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] year_since_1900 = '0;
  logic [3:0]         month = '0;
  logic [4:0]         day_of_month = '0;
  logic [4:0]         hour = '0;
  logic [5:0]         minute = '0;
  logic [5:0]         second = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [63:0] epoch_seconds;

  epoch_seconds_predictor epoch_pred = new();
  int cycles = 0;
  bit random_phase = 1'b0;

  broken_down_date_to_epoch_seconds_top uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .year_since_1900(year_since_1900),
    .month(month),
    .day_of_month(day_of_month),
    .hour(hour),
    .minute(minute),
    .second(second),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .epoch_seconds(epoch_seconds)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      epoch_pred.check_seconds(epoch_seconds);
    end
    if (cycles >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_date(input int y, input logic [3:0] mo, input logic [4:0] d,
                           input logic [4:0] h, input logic [5:0] mi, input logic [5:0] s);
    @(negedge clk);
    in_valid <= 1'b1;
    year_since_1900 <= y;
    month <= mo;
    day_of_month <= d;
    hour <= h;
    minute <= mi;
    second <= s;
    do @(posedge clk); while (!in_ready);
    epoch_pred.note_date(y, mo, d, h, mi, s);
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  function automatic void random_date(output int y, output logic [3:0] mo,
                                      output logic [4:0] d, output logic [4:0] h,
                                      output logic [5:0] mi, output logic [5:0] s);
    int edge_year;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: y = int'($urandom_range(0, 800)) - 200;
      4, 5:       y = int'($urandom);
      6: begin
        case ($urandom_range(0, 3))
          0:       edge_year = FoldAbove;
          1:       edge_year = FoldBelow;
          2:       edge_year = FoldAbove + YearsPerCycle;
          default: edge_year = FoldBelow - YearsPerCycle;
        endcase
        y = edge_year + int'($urandom_range(0, 4)) - 2;
      end
      7: begin
        y = int'($urandom_range(0, 5000000)) * YearsPerCycle + FoldAbove
            + int'($urandom_range(0, 6)) - 3;
        if ($urandom_range(0, 1) == 1) begin
          y = -y;
        end
      end
      default: y = int'($urandom_range(0, 200000)) - 100000;
    endcase
    mo = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 11));
    d = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 31));
    h = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 23));
    mi = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 59));
    s = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 60));
  endfunction

  initial begin
    int hold;
    int span;
    bit pressed;
    bit gappy;
    hold = 0;
    span = 0;
    pressed = 1'b0;
    gappy = 1'b0;
    forever begin
      @(negedge clk);
      span++;
      if (span == 400) begin
        span = 0;
        gappy = !gappy;
      end
      if (random_phase && !pressed) begin
        pressed = 1'b1;
        hold = PressureCycles;
      end else if (hold == 0 && gappy && $urandom_range(0, 3) == 0) begin
        hold = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(20, 100);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int y;
    logic [3:0] mo;
    logic [4:0] d;
    logic [4:0] h;
    logic [5:0] mi;
    logic [5:0] s;
    int gap;
    int r;
    bit busy;
    busy = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_date(32'sh8000_0000, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0);
    send_date(32'sh7fff_ffff, 4'd11, 5'd31, 5'd23, 6'd59, 6'd60);
    send_date(70, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0);
    send_date(69, 4'd11, 5'd31, 5'd23, 6'd59, 6'd59);
    send_date(0, 4'd2, 5'd1, 5'd0, 6'd0, 6'd0);
    send_date(-1900, 4'd1, 5'd29, 5'd12, 6'd30, 6'd30);
    send_date(101, 4'd5, 5'd15, 5'd6, 6'd7, 6'd8);
    send_date(-300, 4'd7, 5'd9, 5'd10, 6'd11, 6'd12);
    send_date(-301, 4'd3, 5'd4, 5'd5, 6'd6, 6'd7);
    send_date(499, 4'd11, 5'd31, 5'd23, 6'd59, 6'd59);
    send_date(500, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0);
    send_date(130, 4'd12, 5'd10, 5'd1, 6'd2, 6'd3);
    send_date(130, 4'd15, 5'd10, 5'd1, 6'd2, 6'd3);
    send_date(124, 4'd6, 5'd0, 5'd0, 6'd0, 6'd0);
    send_date(-1, 4'd9, 5'd20, 5'd31, 6'd63, 6'd63);
    for (int m = 0; m <= December; m++) begin
      send_date(100, 4'(m), 5'd29, 5'(m), 6'(m * 5), 6'(m * 4));
    end

    random_phase = 1'b1;
    for (int i = 0; i < RandomDates; i++) begin
      if (i % 64 == 0) begin
        busy = ($urandom_range(0, 2) == 0);
      end
      random_date(y, mo, d, h, mi, s);
      send_date(y, mo, d, h, mi, s);
      if (!busy) begin
        r = $urandom_range(0, 19);
        if (r < 10) begin
          gap = 0;
        end else if (r < 17) begin
          gap = $urandom_range(1, 3);
        end else if (r < 19) begin
          gap = $urandom_range(4, 10);
        end else begin
          gap = $urandom_range(20, 80);
        end
        idle_for(gap);
      end
    end
    idle_for(1);

    while (epoch_pred.pending() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (epoch_pred.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
